/* design/sbsm_pkg.sv */
// ----------------------------------------------------------------------------
// Serial bank switch mapper package
// Types and codes shared by the mapper core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sbsm_pkg;

	typedef enum logic [1:0] {
		ACT_CPU_WRITE = 2'd0,
		ACT_CPU_READ  = 2'd1,
		ACT_PPU_READ  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		TGT_NONE      = 3'd0,
		TGT_CPU_RAM   = 3'd1,
		TGT_PRG_ROM   = 3'd2,
		TGT_PRG_RAM   = 3'd3,
		TGT_CHR_ROM   = 3'd4,
		TGT_CHR_RAM   = 3'd5,
		TGT_NAMETABLE = 3'd6
	} target_t;

	typedef enum logic [1:0] {
		MIR_ONE_LOW    = 2'd0,
		MIR_ONE_HIGH   = 2'd1,
		MIR_VERTICAL   = 2'd2,
		MIR_HORIZONTAL = 2'd3
	} mirror_t;

	typedef enum logic [1:0] {
		PRG_SWITCH_32K_A = 2'd0,
		PRG_SWITCH_32K_B = 2'd1,
		PRG_FIX_FIRST    = 2'd2,
		PRG_FIX_LAST     = 2'd3
	} prg_mode_t;

	localparam logic [1:0] REG_SEL_CONTROL  = 2'd0;
	localparam logic [1:0] REG_SEL_CHR_LOW  = 2'd1;
	localparam logic [1:0] REG_SEL_CHR_HIGH = 2'd2;
	localparam logic [1:0] REG_SEL_PRG      = 2'd3;

	localparam logic [1:0] CFG_PRG_ROM_BANKS = 2'd0;
	localparam logic [1:0] CFG_PRG_RAM       = 2'd1;
	localparam logic [1:0] CFG_CHR_RAM       = 2'd2;

	localparam logic [7:0] SHIFT_MARK = 8'h80;
	localparam logic [7:0] PPU_TOP_HI = 8'h3F;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [31:0] cycle;
	} item_t;

	typedef struct packed {
		logic [7:0]  shifter;
		prg_mode_t   prg_mode;
		logic        chr_mode;
		logic [3:0]  prg_bank;
		logic [4:0]  chr_low;
		logic [4:0]  chr_high;
		mirror_t     mirror;
		logic [31:0] last_cycle;
	} state_t;

	typedef struct packed {
		logic [4:0] prg_rom_banks;
		logic       prg_ram;
		logic       chr_ram;
	} cfg_t;

	typedef struct packed {
		target_t     target;
		logic [17:0] offset;
		logic        taken;
	} result_t;

endpackage

`default_nettype wire

/* design/sbsm_core.sv */
// ----------------------------------------------------------------------------
// Serial bank switch mapper core
// Decodes one bus transaction against the mapper state: serial loader update
// for CPU writes, target and byte offset for CPU and PPU lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsm_core (
	input  sbsm_pkg::item_t   item,
	input  sbsm_pkg::state_t  st,
	input  sbsm_pkg::cfg_t    cfg,
	output sbsm_pkg::state_t  nxt,
	output sbsm_pkg::result_t res
);
	import sbsm_pkg::*;

	always_comb begin
		logic [7:0]  shifted;
		logic [4:0]  v;
		logic [3:0]  last_bank;
		logic [11:0] nt;
		logic [31:0] gap;

		nxt        = st;
		res.target = TGT_NONE;
		res.offset = '0;
		res.taken  = 1'b0;
		shifted    = {item.data[0], st.shifter[7:1]};
		v          = shifted[7:3];
		last_bank  = 4'(cfg.prg_rom_banks - 5'd1);
		nt         = item.addr[11:0];
		gap        = item.cycle - st.last_cycle;

		case (action_t'(item.action))
			ACT_CPU_WRITE: begin
				if (item.addr[15]) begin
					if (item.data[7]) begin
						nxt.shifter  = SHIFT_MARK;
						nxt.prg_mode = PRG_FIX_LAST;
						res.taken    = 1'b1;
					end else if (gap > 32'd1) begin
						res.taken   = 1'b1;
						nxt.shifter = shifted;
						if (shifted[2]) begin
							case (item.addr[14:13])
								REG_SEL_PRG: begin
									nxt.prg_bank = {v[3:1], v[0] & st.prg_mode[1]};
								end
								REG_SEL_CHR_HIGH: nxt.chr_high = v;
								REG_SEL_CHR_LOW: nxt.chr_low = v;
								default: begin
									nxt.mirror   = mirror_t'(v[1:0]);
									nxt.prg_mode = prg_mode_t'(v[3:2]);
									nxt.chr_mode = v[4];
								end
							endcase
							nxt.shifter = SHIFT_MARK;
						end
					end
					nxt.last_cycle = item.cycle;
				end
			end
			ACT_CPU_READ: begin
				if (item.addr[15:13] == 3'd0) begin
					res.target = TGT_CPU_RAM;
					res.offset = {7'd0, item.addr[10:0]};
				end else if (item.addr[15]) begin
					res.target = TGT_PRG_ROM;
					case (st.prg_mode)
						PRG_FIX_FIRST: begin
							if (item.addr[14])
								res.offset = {st.prg_bank, item.addr[13:0]};
							else
								res.offset = {4'd0, item.addr[13:0]};
						end
						PRG_FIX_LAST: begin
							if (item.addr[14])
								res.offset = {last_bank, item.addr[13:0]};
							else
								res.offset = {st.prg_bank, item.addr[13:0]};
						end
						default: res.offset = {st.prg_bank[3:1], item.addr[14:0]};
					endcase
				end else if (item.addr[14:13] == 2'b11 && cfg.prg_ram) begin
					res.target = TGT_PRG_RAM;
					res.offset = {5'd0, item.addr[12:0]};
				end
			end
			ACT_PPU_READ: begin
				if (item.addr[15:8] < PPU_TOP_HI) begin
					if (item.addr[15:13] == 3'd0) begin
						res.target = cfg.chr_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
						if (st.chr_mode) begin
							if (item.addr[12])
								res.offset = {1'b0, st.chr_high, item.addr[11:0]};
							else
								res.offset = {1'b0, st.chr_low, item.addr[11:0]};
						end else begin
							res.offset = {1'b0, st.chr_low[4:1], item.addr[12:0]};
						end
					end else begin
						res.target = TGT_NAMETABLE;
						case (st.mirror)
							MIR_ONE_LOW: res.offset = {8'd0, nt[9:0]};
							MIR_ONE_HIGH: res.offset = {6'd0, 2'b10, nt[9:0]};
							MIR_VERTICAL: res.offset = {7'd0, nt[10:0]};
							default: res.offset = {7'd0, nt[11], nt[9:0]};
						endcase
					end
				end
			end
			default: begin
				res.target = TGT_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/serial_bank_switch_mapper_unit.sv */
// ----------------------------------------------------------------------------
// Serial bank switch mapper unit
// Cartridge bank mapper with a five-write serial loader and CPU/PPU address
// mapping.
// ----------------------------------------------------------------------------
// The unit takes one bus transaction per cycle while in_stall is low and
// returns exactly one result transaction for each, in order. A transaction is
// captured in an input register and decoded into a result register once the
// output side can advance; the sustained rate is one transaction per cycle
// while the output is not stalled. Mapper state is updated on the same edge
// that loads the result register, so every transaction sees the effect of all
// writes accepted before it. The configuration registers should only be
// written while no transaction is in flight.
`default_nettype none

module serial_bank_switch_mapper_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] bus_address,
	input  wire logic [7:0]  write_data,
	input  wire logic [31:0] cpu_cycle,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       target,
	output logic [17:0]      byte_offset,
	output logic             write_taken
);
	import sbsm_pkg::*;

	logic    s1_valid;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	state_t  state_q;
	cfg_t    cfg_q;
	state_t  state_nxt;
	result_t res_nxt;
	logic    s1_adv;
	logic    in_acc;

	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = s1_valid && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	sbsm_core u_core (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_acc) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.action <= action;
			item_s1.addr   <= bus_address;
			item_s1.data   <= write_data;
			item_s1.cycle  <= cpu_cycle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_adv) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.shifter    <= SHIFT_MARK;
			state_q.prg_mode   <= PRG_FIX_LAST;
			state_q.chr_mode   <= 1'b0;
			state_q.prg_bank   <= '0;
			state_q.chr_low    <= '0;
			state_q.chr_high   <= '0;
			state_q.mirror     <= MIR_HORIZONTAL;
			state_q.last_cycle <= '0;
		end else if (s1_valid && s1_adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prg_rom_banks <= 5'd16;
			cfg_q.prg_ram       <= 1'b1;
			cfg_q.chr_ram       <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PRG_ROM_BANKS: cfg_q.prg_rom_banks <= cfg_data;
				CFG_PRG_RAM: cfg_q.prg_ram <= cfg_data[0];
				CFG_CHR_RAM: cfg_q.chr_ram <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign target      = res_q.target;
	assign byte_offset = res_q.offset;
	assign write_taken = res_q.taken;

	// The loader always restarts before the marker bit reaches bit two.
	a_shifter_marker: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.shifter[2:0] == 3'd0)
		else $error("serial loader holds a completed load");

	a_none_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.target == TGT_NONE |-> res_q.offset == 18'd0)
		else $error("result without target carries an offset");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_valid_q && out_stall |=> s1_valid && $stable(item_s1))
		else $error("input stage lost a transaction under output stall");

	a_taken_write: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && s1_adv && res_nxt.taken |=>
			out_valid_q && $past(item_s1.action) == ACT_CPU_WRITE
			&& res_q.target == TGT_NONE)
		else $error("loader activity reported for a lookup");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Serial bank switch mapper unit testbench
// Sends CPU writes and CPU/PPU address lookups through the valid/stall
// channels and predicts each result from a cycle-free model of the serial
// loader, bank registers and mirroring. Every result is compared field by
// field in order. Directed corner cases come first, then random traffic
// under several configuration settings, a long output hold-off and a
// stretch with no idling on either side.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sbsm_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [31:0] IO_LO = 32'h2000;
	localparam logic [31:0] WRAM_LO = 32'h6000;
	localparam logic [31:0] ROM_LO = 32'h8000;
	localparam logic [31:0] ROM_HI = 32'hC000;
	localparam logic [31:0] PRG_UNIT = 32'h4000;
	localparam logic [31:0] CHR_UNIT = 32'h1000;
	localparam logic [31:0] SCREEN_HI = 32'h800;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [4:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = '0;
	logic [15:0] bus_address = '0;
	logic [7:0]  write_data = '0;
	logic [31:0] cpu_cycle = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  target;
	logic [17:0] byte_offset;
	logic        write_taken;

	// Mapper state and configuration as the testbench sees them.
	logic [7:0]  sh_reg = SHIFT_MARK;
	logic [1:0]  pmode = PRG_FIX_LAST;
	logic        cmode = 1'b0;
	logic [3:0]  pbank = '0;
	logic [4:0]  cbank_lo = '0;
	logic [4:0]  cbank_hi = '0;
	logic [1:0]  mirr = MIR_HORIZONTAL;
	logic [31:0] last_cyc = '0;
	logic [4:0]  rom_banks = 5'd16;
	logic        has_wram = 1'b1;
	logic        has_chr_ram = 1'b0;

	result_t     bus_replies[$];
	int          replies_due = 0;
	logic [31:0] cyc_now = '0;
	bit          valid_up = 1'b0;
	int          tx_gap = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int          hold_len = 0;
	bit          hold_active = 1'b0;

	int n_sent = 0, n_writes = 0, n_cpu = 0, n_ppu = 0, n_other = 0;
	int n_loads = 0, n_ignored = 0, n_settings = 0, n_checked = 0, n_fail = 0;

	serial_bank_switch_mapper_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.bus_address(bus_address),
		.write_data(write_data),
		.cpu_cycle(cpu_cycle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.target(target),
		.byte_offset(byte_offset),
		.write_taken(write_taken)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the reply to one bus transaction and applies its side effects.
	function automatic result_t decode_access(input item_t it);
		result_t     r;
		logic [31:0] off;
		logic [31:0] dt;
		logic [4:0]  v;
		logic [3:0]  last_bank;
		logic [11:0] nt;
		logic [31:0] a;
		a = 32'(it.addr);
		off = '0;
		r.target = TGT_NONE;
		r.taken = 1'b0;
		case (it.action)
			ACT_CPU_WRITE: begin
				n_writes++;
				if (a[15] && it.data[7]) begin
					sh_reg = SHIFT_MARK;
					pmode = PRG_FIX_LAST;
					last_cyc = it.cycle;
					r.taken = 1'b1;
				end else if (a[15]) begin
					dt = it.cycle - last_cyc;
					if (dt > 32'd1) begin
						r.taken = 1'b1;
						sh_reg = {it.data[0], sh_reg[7:1]};
						if (sh_reg[2]) begin
							v = sh_reg[7:3];
							n_loads++;
							case (a[14:13])
								REG_SEL_PRG: begin
									pbank = v[3:0];
									if (!pmode[1])
										pbank[0] = 1'b0;
								end
								REG_SEL_CHR_HIGH: cbank_hi = v;
								REG_SEL_CHR_LOW: cbank_lo = v;
								default: begin
									mirr = v[1:0];
									pmode = v[3:2];
									cmode = v[4];
								end
							endcase
							sh_reg = SHIFT_MARK;
						end
					end else begin
						n_ignored++;
					end
					last_cyc = it.cycle;
				end
			end
			ACT_CPU_READ: begin
				n_cpu++;
				last_bank = rom_banks[3:0] - 4'd1;
				if (a < IO_LO) begin
					r.target = TGT_CPU_RAM;
					off = 32'(a[10:0]);
				end else if (a >= ROM_LO) begin
					r.target = TGT_PRG_ROM;
					case (pmode)
						PRG_SWITCH_32K_A, PRG_SWITCH_32K_B:
							off = 32'({pbank[3:1], 1'b0}) * PRG_UNIT + (a - ROM_LO);
						PRG_FIX_FIRST: begin
							if (a < ROM_HI)
								off = a - ROM_LO;
							else
								off = 32'(pbank) * PRG_UNIT + (a - ROM_HI);
						end
						default: begin
							if (a >= ROM_HI)
								off = 32'(last_bank) * PRG_UNIT + (a - ROM_HI);
							else
								off = 32'(pbank) * PRG_UNIT + (a - ROM_LO);
						end
					endcase
				end else if (a >= WRAM_LO && has_wram) begin
					r.target = TGT_PRG_RAM;
					off = a - WRAM_LO;
				end
			end
			ACT_PPU_READ: begin
				n_ppu++;
				nt = a[11:0];
				if (a[15:8] >= PPU_TOP_HI) begin
					r.target = TGT_NONE;
				end else if (a < IO_LO) begin
					r.target = has_chr_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
					if (!cmode)
						off = 32'({cbank_lo[4:1], 1'b0}) * CHR_UNIT + 32'(a[12:0]);
					else if (a[12])
						off = 32'(cbank_hi) * CHR_UNIT + 32'(a[11:0]);
					else
						off = 32'(cbank_lo) * CHR_UNIT + 32'(a[11:0]);
				end else begin
					r.target = TGT_NAMETABLE;
					case (mirr)
						MIR_ONE_LOW: off = 32'(nt[9:0]);
						MIR_ONE_HIGH: off = 32'(nt[9:0]) + SCREEN_HI;
						MIR_VERTICAL: off = 32'(nt[10:0]);
						default: off = 32'({nt[11], nt[9:0]});
					endcase
				end
			end
			default: n_other++;
		endcase
		r.offset = off[17:0];
		return r;
	endfunction

	function automatic int pick_pause(input bit on);
		int r;
		r = $urandom_range(0, 99);
		if (!on || r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Strict steps keep consecutive mapper writes far enough apart to count.
	function automatic logic [31:0] next_cycle(input bit strict);
		int r;
		r = $urandom_range(0, 99);
		if (strict || r < 80)
			cyc_now = cyc_now + $urandom_range(2, 12);
		else if (r < 88)
			cyc_now = cyc_now + $urandom_range(0, 1);
		else if (r < 95)
			cyc_now = cyc_now + $urandom;
		else
			cyc_now = $urandom;
		return cyc_now;
	endfunction

	// Valid is lowered at the acceptance edge only when a gap follows, so that
	// back-to-back transactions never see it dropped and raised in one step.
	task automatic send_item(input logic [1:0] act, input logic [15:0] addr,
			input logic [7:0] data, input logic [31:0] cyc);
		item_t it;
		it.action = act;
		it.addr = addr;
		it.data = data;
		it.cycle = cyc;
		if (tx_gap > 0) begin
			repeat (tx_gap) @(posedge clk);
			tx_gap = 0;
		end
		action <= act;
		bus_address <= addr;
		write_data <= data;
		cpu_cycle <= cyc;
		if (!valid_up) begin
			in_valid <= 1'b1;
			valid_up = 1'b1;
		end
		do @(posedge clk); while (in_stall);
		bus_replies.push_back(decode_access(it));
		replies_due++;
		n_sent++;
		tx_gap = pick_pause(tx_idle_on);
		if (tx_gap > 0) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
	endtask

	task automatic tx_rest();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
		tx_gap = 0;
	endtask

	task automatic wait_drain();
		tx_rest();
		wait (replies_due == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_config(input logic [4:0] banks, input logic wram,
			input logic chrram, input bit poke_unused);
		logic [4:0] d;
		wait_drain();
		cfg_write <= 1'b1;
		cfg_index <= CFG_PRG_ROM_BANKS;
		cfg_data <= banks;
		@(posedge clk);
		d = 5'($urandom);
		d[0] = wram;
		cfg_index <= CFG_PRG_RAM;
		cfg_data <= d;
		@(posedge clk);
		d = 5'($urandom);
		d[0] = chrram;
		cfg_index <= CFG_CHR_RAM;
		cfg_data <= d;
		@(posedge clk);
		if (poke_unused) begin
			d = 5'($urandom);
			cfg_index <= CFG_UNUSED;
			cfg_data <= d;
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		rom_banks = banks;
		has_wram = wram;
		has_chr_ram = chrram;
		n_settings++;
		@(posedge clk);
	endtask

	// A loader reset followed by five data writes to one register window;
	// a broken load slips in one back-to-back write that must be ignored.
	task automatic send_load(input logic [1:0] sel, input logic [4:0] val, input bit broken);
		logic [15:0] a;
		logic [7:0]  d;
		int          k;
		int          cut;
		cut = broken ? $urandom_range(0, 4) : 5;
		a = 16'($urandom);
		a[15] = 1'b1;
		d = 8'($urandom);
		d[7] = 1'b1;
		send_item(ACT_CPU_WRITE, a, d, next_cycle(1'b1));
		for (k = 0; k < 5; k++) begin
			a = 16'($urandom);
			a[15] = 1'b1;
			a[14:13] = sel;
			d = 8'($urandom);
			d[7] = 1'b0;
			d[0] = val[k];
			if (k == cut) begin
				cyc_now = cyc_now + $urandom_range(0, 1);
				send_item(ACT_CPU_WRITE, a, d, cyc_now);
			end
			send_item(ACT_CPU_WRITE, a, d, next_cycle(1'b1));
		end
	endtask

	task automatic send_lookup();
		logic [15:0] a;
		logic [7:0]  d;
		int          r;
		a = 16'($urandom);
		d = 8'($urandom);
		r = $urandom_range(0, 9);
		if ($urandom_range(0, 1)) begin
			if (r < 2)
				a[15:13] = 3'b000;
			else if (r < 4)
				a[15:13] = 3'b011;
			else if (r < 8)
				a[15] = 1'b1;
			send_item(ACT_CPU_READ, a, d, next_cycle(1'b1));
		end else begin
			if (r < 4)
				a[15:13] = 3'b000;
			else if (r < 8)
				a = 16'(32'h2000 + $urandom_range(0, 32'h1EFF));
			send_item(ACT_PPU_READ, a, d, next_cycle(1'b1));
		end
	endtask

	task automatic run_traffic(input int count);
		int          stop;
		int          r;
		logic [15:0] a;
		logic [7:0]  d;
		stop = n_sent + count;
		while (n_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				d = 8'($urandom);
				send_load(d[1:0], d[6:2], $urandom_range(0, 9) == 0);
				repeat ($urandom_range(1, 4)) send_lookup();
			end else if (r < 85) begin
				send_lookup();
			end else begin
				a = 16'($urandom);
				d = 8'($urandom);
				send_item(2'($urandom_range(0, 3)), a, d, next_cycle(1'b0));
			end
		end
	endtask

	task automatic test_directed();
		send_item(ACT_CPU_WRITE, 16'h8000, 8'h01, 32'd1);
		send_item(ACT_CPU_WRITE, 16'h7FFF, 8'hFF, 32'd100);
		send_item(ACT_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(ACT_CPU_READ, 16'h0000, 8'h00, 32'd200);
		send_item(ACT_CPU_READ, 16'h1FFF, 8'h00, 32'd200);
		send_item(ACT_CPU_READ, 16'h2000, 8'h00, 32'd200);
		send_item(ACT_CPU_READ, 16'h7FFF, 8'h00, 32'd200);
		send_item(ACT_CPU_READ, 16'h8000, 8'h00, 32'd200);
		send_item(ACT_CPU_READ, 16'hFFFF, 8'h00, 32'd200);
		send_item(ACT_PPU_READ, 16'h1FFF, 8'h00, 32'd200);
		send_item(ACT_PPU_READ, 16'h2C05, 8'h00, 32'd200);
		send_item(ACT_PPU_READ, 16'h3EFF, 8'h00, 32'd200);
		send_item(ACT_PPU_READ, 16'h3F00, 8'h00, 32'd200);
		cyc_now = 32'd300;
		send_load(REG_SEL_CONTROL, 5'b10001, 1'b0);
		cyc_now = cyc_now + 32'd1;
		send_item(ACT_CPU_WRITE, 16'hE000, 8'h00, cyc_now);
		send_item(ACT_CPU_READ, 16'hC000, 8'h00, next_cycle(1'b1));
		send_item(ACT_PPU_READ, 16'h1000, 8'h00, next_cycle(1'b1));
		send_item(ACT_PPU_READ, 16'h2400, 8'h00, next_cycle(1'b1));
	endtask

	task automatic test_config_sweep();
		logic [4:0] banks[6] = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd8, 5'd3};
		logic       wram[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		logic       chrram[6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
		int         i;
		run_traffic(150);
		for (i = 0; i < 6; i++) begin
			program_config(banks[i], wram[i], chrram[i], i == 0);
			run_traffic(170);
		end
	endtask

	task automatic test_output_hold();
		tx_idle_on = 1'b0;
		tx_rest();
		hold_len = 100;
		wait (hold_active);
		run_traffic(40);
		tx_idle_on = 1'b1;
		wait_drain();
	endtask

	task automatic test_steady_stream();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_traffic(200);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		wait_drain();
	endtask

	task automatic test_random_settings();
		int i;
		for (i = 0; i < 3; i++) begin
			program_config(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			run_traffic(100);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_output_hold();
		test_steady_stream();
		test_random_settings();
		wait_drain();
		repeat (6) @(posedge clk);
		$display("Covered %0d transactions: %0d writes, %0d CPU lookups,",
			n_sent, n_writes, n_cpu);
		$display("%0d PPU lookups, %0d unused, %0d results checked, %0d register loads,",
			n_ppu, n_other, n_checked, n_loads);
		$display("%0d back-to-back writes and %0d settings.", n_ignored, n_settings);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Result side: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				hold_active = 1'b1;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				hold_active = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (1 + pick_pause(1'b1)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bus_replies.size() == 0) begin
				$error("result transaction with nothing outstanding: target %0d offset %h",
					target, byte_offset);
				n_fail++;
			end else begin
				want = bus_replies.pop_front();
				replies_due--;
				n_checked++;
				if (target !== want.target) begin
					$error("target: expected %0d, actual %0d", want.target, target);
					n_fail++;
				end
				if (byte_offset !== want.offset) begin
					$error("byte_offset: expected %h, actual %h", want.offset, byte_offset);
					n_fail++;
				end
				if (write_taken !== want.taken) begin
					$error("write_taken: expected %0d, actual %0d", want.taken, write_taken);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#(10_000_000);
		$display("Test completed with failures");
		$finish;
	end

endmodule
